>>> hdl/b64enc_pkg.sv
// package: item types, job type and the character table of the base64 encoder
`timescale 1ns / 1ps
`default_nettype none
package b64enc_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3d;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       message_end;
    } out_item_t;

    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            msg_last;
    } job_t;

    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] ch;
        if (v < 6'd26) begin
            ch = 8'h41 + {2'b00, v};
        end
        else if (v < 6'd52) begin
            ch = 8'h61 + {2'b00, v} - 8'd26;
        end
        else if (v < 6'd62) begin
            ch = 8'h30 + {2'b00, v} - 8'd52;
        end
        else if (v == 6'd62) begin
            ch = 8'h2b;
        end
        else begin
            ch = 8'h2f;
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

>>> hdl/base64_stream_encoder_unit.sv
// top level: streaming base64 encoder, bytes in, characters out
//
// channel   direction  handshake     payload
// input     in         push / full   in_data  (data_byte, message_last)
// result    out        pop / empty   out_data (out_char, run_last, message_end)
//
// a byte becomes a job of one to four characters in the same cycle it is taken
// characters leave the output register one per cycle while pop is held, so a byte
// yields one or two characters, and two to four at message end
// full rises while the job queue holds QUEUE_DEPTH jobs not yet fully sent
// reset clears group position, leftover bits, queue counts and the output valid flag
`timescale 1ns / 1ps
`default_nettype none
module base64_stream_encoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire b64enc_pkg::in_item_t  in_data,
    output logic                       empty,
    input  wire logic                  pop,
    output b64enc_pkg::out_item_t      out_data
);

    b64enc_pkg::job_t new_job;
    b64enc_pkg::job_t head_job;
    logic             take;
    logic             head_valid;
    logic             head_done;

    assign take = push && !full;

    b64enc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_data (in_data),
        .job     (new_job)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (take),
        .wr_job   (new_job),
        .full     (full),
        .rd_en    (head_done),
        .rd_job   (head_job),
        .rd_valid (head_valid)
    );

    b64enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .job_done  (head_done),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data)
    );

    a_done_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        head_done |-> head_valid)
        else $error("job retired from empty queue");

    a_full_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> head_valid)
        else $error("queue full without head job");

    a_last_pads: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_data.message_last) |-> (new_job.last_idx != 2'd0))
        else $error("final byte without flush characters");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!head_valid && pop && !empty) |=> empty)
        else $error("result appeared without a job");

endmodule
`default_nettype wire

>>> hdl/b64enc_front.sv
// front end: tracks group position and leftover bits, turns each byte into a job
`timescale 1ns / 1ps
`default_nettype none
module b64enc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire b64enc_pkg::in_item_t in_data,
    output b64enc_pkg::job_t        job
);

    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] left_reg;
    logic [3:0] left_next;
    logic [7:0] b;
    logic       last;

    assign b    = in_data.data_byte;
    assign last = in_data.message_last;

    always_comb
    begin
        job.chars    = {4{b64enc_pkg::PAD_CHAR}};
        job.last_idx = 2'd0;
        job.msg_last = last;
        phase_next   = phase_reg;
        left_next    = left_reg;
        unique case (phase_reg)
            PH_1:
            begin
                job.chars[0] = b64enc_pkg::sym({left_reg[1:0], b[7:4]});
                left_next    = b[3:0];
                phase_next   = PH_2;
                if (last)
                begin
                    job.chars[1] = b64enc_pkg::sym({b[3:0], 2'b00});
                    job.last_idx = 2'd2;
                end
            end
            PH_2:
            begin
                job.chars[0] = b64enc_pkg::sym({left_reg, b[7:6]});
                job.chars[1] = b64enc_pkg::sym(b[5:0]);
                job.last_idx = 2'd1;
                left_next    = 4'd0;
                phase_next   = PH_0;
            end
            default:
            begin
                job.chars[0] = b64enc_pkg::sym(b[7:2]);
                left_next    = {2'b00, b[1:0]};
                phase_next   = PH_1;
                if (last)
                begin
                    job.chars[1] = b64enc_pkg::sym({b[1:0], 4'b0000});
                    job.last_idx = 2'd3;
                end
            end
        endcase
        if (last)
        begin
            phase_next = PH_0;
            left_next  = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_0;
            left_reg  <= 4'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/b64enc_queue.sv
// job queue between front end and serializer
`timescale 1ns / 1ps
`default_nettype none
module b64enc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire b64enc_pkg::job_t wr_job,
    output logic                  full,
    input  wire logic             rd_en,
    output b64enc_pkg::job_t      rd_job,
    output logic                  rd_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64enc_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/b64enc_back.sv
// back end: loads head job chars one per cycle into output register when free or popped
`timescale 1ns / 1ps
`default_nettype none
module b64enc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               job_valid,
    input  wire b64enc_pkg::job_t   job,
    output logic                    job_done,
    output logic                    empty,
    input  wire logic               pop,
    output b64enc_pkg::out_item_t   out_data
);

    logic [1:0]            idx_reg;
    logic [1:0]            idx_next;
    logic                  valid_reg;
    logic                  valid_next;
    b64enc_pkg::out_item_t item_reg;
    b64enc_pkg::out_item_t item_next;
    logic                  advance;
    logic                  at_end;

    assign empty    = !valid_reg;
    assign out_data = item_reg;
    assign advance  = job_valid && (!valid_reg || pop);
    assign at_end   = (idx_reg == job.last_idx);
    assign job_done = advance && at_end;

    always_comb
    begin
        idx_next              = idx_reg;
        valid_next            = valid_reg;
        item_next             = item_reg;
        if (advance)
        begin
            item_next.out_char    = job.chars[idx_reg];
            item_next.run_last    = at_end;
            item_next.message_end = at_end && job.msg_last;
            valid_next            = 1'b1;
            idx_next              = at_end ? 2'd0 : idx_reg + 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

endmodule
`default_nettype wire
